// ===== hdl/aeau_pkg.sv =====
// Package for the array element address unit: field widths, table sizes,
// request codes and the command and status structs shared by the controller and datapath.
// Depends on nothing.
package aeau_pkg;

  localparam int NUM_ARRAYS = 16;
  localparam int MAX_DIMS   = 10;

  localparam int REQ_W   = 2;
  localparam int ID_W    = 4;
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int DIMS_W  = 4;
  localparam int BOUND_W = 16;
  localparam int EXT_W   = 17;

  localparam int AID_W     = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int TBL_DEPTH = NUM_ARRAYS * MAX_DIMS;
  localparam int TA_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int POS_W     = $clog2(MAX_DIMS + 1);
  localparam int ENTRY_W   = BOUND_W + EXT_W;

  localparam int ACC_W = 42;
  localparam int SPLIT = 21;
  localparam int SUM_W = 61;

  localparam longint OFFSET_LIMIT = 64'sd1 <<< 40;
  localparam longint ADDR_MAX     = 64'sh0000_0000_FFFF_FFFF;

  localparam logic [REQ_W-1:0] REQ_HEADER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BOUND  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic take;
    logic mul_ext;
    logic mul_size;
    logic fold_add;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_query;
    logic fold;
    logic last;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/aeau_if.sv =====
// Handshake interfaces for the input item channel and the result item channel.
// Depends on aeau_pkg.
interface aeau_in_if import aeau_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [ID_W-1:0]           array_id;
  logic [ADDR_W-1:0]         base_address;
  logic [SIZE_W-1:0]         elem_size;
  logic [DIMS_W-1:0]         dim_count;
  logic [DIMS_W-1:0]         dim_number;
  logic signed [BOUND_W-1:0] lower_bound;
  logic signed [BOUND_W-1:0] upper_bound;
  logic signed [BOUND_W-1:0] subscript;
  logic                      last_subscript;

  modport source (
    output valid, req_type, array_id, base_address, elem_size, dim_count,
           dim_number, lower_bound, upper_bound, subscript, last_subscript,
    input  ready
  );
  modport sink (
    input  valid, req_type, array_id, base_address, elem_size, dim_count,
           dim_number, lower_bound, upper_bound, subscript, last_subscript,
    output ready
  );
endinterface

interface aeau_out_if import aeau_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              overflow;

  modport source (output valid, address, overflow, input ready);
  modport sink   (input valid, address, overflow, output ready);
endinterface

// ===== hdl/aeau_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module aeau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/aeau_ctrl.sv =====
// Controller state machine: sequences table lookup, multiply, accumulate and result load.
// Depends on aeau_pkg.
module aeau_ctrl import aeau_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_FADD = 5'b00100,
    S_AMUL = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_valid && status.in_query) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (status.fold) begin
          cmd.mul_ext = 1'b1;
          state_nxt   = S_FADD;
        end else if (status.last) begin
          cmd.mul_size = 1'b1;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FADD: begin
        cmd.fold_add = 1'b1;
        state_nxt    = status.last ? S_AMUL : S_IDLE;
      end
      S_AMUL: begin
        cmd.mul_size = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_query_looks_up: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && status.in_valid && status.in_query) |=> (state_r == S_LOOK))
    else $error("Accepted query item did not start a table lookup.");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("Result loaded while the output register was still full.");

  a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_ext || cmd.mul_size || cmd.fold_add) |-> !cmd.take)
    else $error("New item taken while a query item was still at work.");

endmodule

// ===== hdl/aeau_dp.sv =====
// Datapath: descriptor tables, bound RAM, split offset multiplier, accumulator and
// output register. Depends on aeau_pkg, aeau_if and aeau_ram.
module aeau_dp import aeau_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  aeau_in_if.sink   in_chan,
  aeau_out_if.source out_chan,
  input  cmd_t    cmd,
  output status_t status
);

  logic accept;
  logic in_id_ok;
  logic [15:0] wlin, rlin;
  logic signed [EXT_W-1:0] span;
  logic [EXT_W-1:0] in_ext;
  logic hdr_we, bnd_we;
  logic [AID_W-1:0] in_tidx;

  logic [ADDR_W-1:0] base_tbl_r [NUM_ARRAYS];
  logic [SIZE_W-1:0] size_tbl_r [NUM_ARRAYS];
  logic [DIMS_W-1:0] dims_tbl_r [NUM_ARRAYS];
  logic [NUM_ARRAYS-1:0] tvalid_r;

  logic [ID_W-1:0]           id_r;
  logic signed [BOUND_W-1:0] sub_r;
  logic                      last_r;

  logic [ENTRY_W-1:0] rdata;
  logic signed [BOUND_W-1:0] lower_q;
  logic [EXT_W-1:0] ext_q;

  logic id_ok_q;
  logic [AID_W-1:0] tidx;
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] size_q;
  logic [DIMS_W-1:0] dims_q;
  logic fold;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [ADDR_W-1:0] low32_r, low32_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic mul_en;
  logic [EXT_W-1:0] mul_b;
  logic [37:0] p_lo, p_lo_r;
  logic signed [38:0] p_hi, p_hi_r;
  logic [ADDR_W-1:0] p_w, p_w_r;
  logic signed [17:0] d_nxt, d_r;

  logic signed [33:0] addend;
  logic signed [SUM_W-1:0] sum;
  logic [ADDR_W-1:0] low_sum;
  logic ovf;

  logic out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] address_r, address_nxt;
  logic overflow_r, overflow_nxt;

  assign accept   = in_chan.valid && cmd.take;
  assign in_chan.ready = cmd.take;
  assign in_id_ok = int'(in_chan.array_id) < NUM_ARRAYS;
  assign in_tidx  = AID_W'(in_chan.array_id);
  assign wlin     = 16'(in_chan.array_id) * 16'(MAX_DIMS) + 16'(in_chan.dim_number);
  assign rlin     = 16'(in_chan.array_id) * 16'(MAX_DIMS) + 16'(pos_r);
  assign span     = EXT_W'(in_chan.upper_bound) - EXT_W'(in_chan.lower_bound);
  assign in_ext   = span[EXT_W-1] ? '0 : EXT_W'(span) + EXT_W'(1);
  assign hdr_we   = accept && (in_chan.req_type == REQ_HEADER) && in_id_ok;
  assign bnd_we   = accept && (in_chan.req_type == REQ_BOUND) && in_id_ok &&
                    (int'(in_chan.dim_number) < MAX_DIMS);

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      base_tbl_r[in_tidx] <= in_chan.base_address;
      size_tbl_r[in_tidx] <= in_chan.elem_size;
      dims_tbl_r[in_tidx] <= in_chan.dim_count;
    end
    if (accept) begin
      id_r   <= in_chan.array_id;
      sub_r  <= in_chan.subscript;
      last_r <= in_chan.last_subscript;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= '0;
    end else if (hdr_we) begin
      tvalid_r[in_tidx] <= 1'b1;
    end
  end

  aeau_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TBL_DEPTH)
  ) u_bound_ram (
    .clk  (clk),
    .we   (bnd_we),
    .waddr(TA_W'(wlin)),
    .wdata({in_chan.lower_bound, in_ext}),
    .raddr(TA_W'(rlin)),
    .rdata(rdata)
  );

  assign lower_q = rdata[ENTRY_W-1:EXT_W];
  assign ext_q   = rdata[EXT_W-1:0];

  assign id_ok_q = int'(id_r) < NUM_ARRAYS;
  assign tidx    = AID_W'(id_r);
  assign base_q  = (id_ok_q && tvalid_r[tidx]) ? base_tbl_r[tidx] : '0;
  assign size_q  = (id_ok_q && tvalid_r[tidx]) ? size_tbl_r[tidx] : '0;
  assign dims_q  = (id_ok_q && tvalid_r[tidx]) ? dims_tbl_r[tidx] : '0;
  assign fold    = (int'(pos_r) < int'(dims_q)) && (int'(pos_r) < MAX_DIMS);

  // The 42-bit offset is multiplied as two halves; the halves are recombined in the adder.
  assign mul_en = cmd.mul_ext || cmd.mul_size;
  assign mul_b  = cmd.mul_size ? EXT_W'(size_q) : ext_q;
  assign p_lo   = 38'(acc_r[SPLIT-1:0]) * 38'(mul_b);
  assign p_hi   = 39'($signed(acc_r[ACC_W-1:SPLIT])) * 39'($signed({1'b0, mul_b}));
  assign p_w    = low32_r * ADDR_W'(mul_b);
  assign d_nxt  = 18'(sub_r) - 18'(lower_q);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_lo_r <= p_lo;
      p_hi_r <= p_hi;
      p_w_r  <= p_w;
      d_r    <= d_nxt;
    end
  end

  assign addend  = cmd.load_out ? $signed({2'b00, base_q}) : 34'(d_r);
  assign sum     = (SUM_W'(p_hi_r) <<< SPLIT) + SUM_W'($signed({1'b0, p_lo_r})) +
                   SUM_W'(addend);
  assign low_sum = p_w_r + addend[ADDR_W-1:0];
  assign ovf     = sum[SUM_W-1] || (sum > ADDR_MAX);

  always_comb begin
    acc_nxt   = acc_r;
    low32_nxt = low32_r;
    pos_nxt   = pos_r;
    priority if (cmd.load_out) begin
      acc_nxt   = '0;
      low32_nxt = '0;
      pos_nxt   = '0;
    end else if (cmd.fold_add) begin
      if (sum > OFFSET_LIMIT) begin
        acc_nxt = ACC_W'(OFFSET_LIMIT);
      end else if (sum < -OFFSET_LIMIT) begin
        acc_nxt = ACC_W'(-OFFSET_LIMIT);
      end else begin
        acc_nxt = ACC_W'(sum);
      end
      low32_nxt = low_sum;
      pos_nxt   = POS_W'(pos_r + 1'b1);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    address_nxt   = address_r;
    overflow_nxt  = overflow_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      address_nxt   = low_sum;
      overflow_nxt  = ovf;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      low32_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      low32_r     <= low32_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    address_r  <= address_nxt;
    overflow_r <= overflow_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.address  = address_r;
  assign out_chan.overflow = overflow_r;

  assign status.in_valid = in_chan.valid;
  assign status.in_query = in_chan.req_type == REQ_QUERY;
  assign status.fold     = fold;
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_chan.ready;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pos_r) <= MAX_DIMS)
    else $error("Query position ran past the dimension limit.");

  a_acc_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r <= OFFSET_LIMIT) && (acc_r >= -OFFSET_LIMIT))
    else $error("Offset accumulator left its saturation range.");

  a_query_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (pos_r == '0) && (acc_r == '0) && (low32_r == '0) && out_valid_r)
    else $error("Query state not cleared when the result was loaded.");

endmodule

// ===== hdl/array_element_address_unit.sv =====
// Array element address unit: header and bound items are taken back to back.
// A subscript item passes through bound RAM read, split multiply and accumulate,
// or only the read with no dimension left; the last subscript adds the dependent
// element-size multiply, after which the result is loaded into the output register,
// later while it is held full. No new item is taken until a subscript item is done.
// Synchronous active-low reset clears descriptor valid bits, query state and result valid.
module array_element_address_unit import aeau_pkg::*; (
  input logic clk,
  input logic rst_n,
  aeau_in_if.sink    in_chan,
  aeau_out_if.source out_chan
);

  cmd_t    cmd;
  status_t status;

  aeau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .status(status),
    .cmd   (cmd)
  );

  aeau_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cmd     (cmd),
    .status  (status)
  );

endmodule
